@@ sv/a2bc_pkg.sv @@
`timescale 1ns / 1ps
package a2bc_pkg;

    localparam int unsigned BLOCK_WORDS = 128;
    localparam int unsigned ADDR_W      = 7;
    localparam int unsigned PAIR_W      = 6;
    localparam logic [63:0] LO32_MASK   = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic [63:0] word;
        logic        last;
    } q_word_t;

    typedef logic [3:0] quad_row_t [0:3];

    localparam logic [3:0] QUAD_IDX [0:7][0:3] = '{
        '{4'd0, 4'd4, 4'd8,  4'd12},
        '{4'd1, 4'd5, 4'd9,  4'd13},
        '{4'd2, 4'd6, 4'd10, 4'd14},
        '{4'd3, 4'd7, 4'd11, 4'd15},
        '{4'd0, 4'd5, 4'd10, 4'd15},
        '{4'd1, 4'd6, 4'd11, 4'd12},
        '{4'd2, 4'd7, 4'd8,  4'd13},
        '{4'd3, 4'd4, 4'd9,  4'd14}
    };

    // rows: 16p + l; columns: 16*(l>>1) + 2i + (l&1)
    function automatic logic [6:0] word_addr(input logic [3:0] p, input logic [3:0] l);
        logic [6:0] a;
        if (!p[3])
        begin
            a = {p[2:0], l};
        end
        else
        begin
            a = {l[3:1], p[2:0], l[0]};
        end
        return a;
    endfunction

    function automatic logic [63:0] rotr(input logic [63:0] w, input int unsigned s);
        return (w >> s) | (w << (64 - s));
    endfunction

endpackage

@@ sv/a2bc_front.sv @@
`timescale 1ns / 1ps
module a2bc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [63:0]          x_word,
    input  logic [63:0]          y_word,
    output logic                 q_valid,
    output a2bc_pkg::q_word_t    q_data,
    input  logic                 q_pop
);
    import a2bc_pkg::*;

    q_word_t     fifo_mem [0:3];
    logic [1:0]  wp_reg, wp_next;
    logic [1:0]  rp_reg, rp_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [6:0]  pos_reg, pos_next;
    logic        do_push, do_pop;

    assign full    = cnt_reg == 3'd4;
    assign q_valid = cnt_reg != 3'd0;
    assign q_data  = fifo_mem[rp_reg];
    assign do_push = push && !full;
    assign do_pop  = q_pop && q_valid;

    always_comb
    begin
        wp_next  = do_push ? wp_reg + 2'd1 : wp_reg;
        rp_next  = do_pop ? rp_reg + 2'd1 : rp_reg;
        pos_next = do_push ? pos_reg + 7'd1 : pos_reg;
        cnt_next = cnt_reg + {2'b00, do_push} - {2'b00, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            fifo_mem[wp_reg] <= '{word: x_word ^ y_word, last: pos_reg == 7'(BLOCK_WORDS - 1)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
            pos_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
            pos_reg <= pos_next;
        end
    end

endmodule

@@ sv/a2bc_back.sv @@
`timescale 1ns / 1ps
module a2bc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  a2bc_pkg::q_word_t    q_data,
    output logic                 q_pop,
    output logic                 empty,
    input  logic                 pop,
    output logic [63:0]          low_word,
    output logic [63:0]          high_word,
    output logic                 last_pair
);
    import a2bc_pkg::*;

    typedef enum logic [8:0] {
        S_LOAD = 9'b000000001,
        S_RDA  = 9'b000000010,
        S_RDB  = 9'b000000100,
        S_RDC  = 9'b000001000,
        S_MUL  = 9'b000010000,
        S_ADD  = 9'b000100000,
        S_WR   = 9'b001000000,
        S_EMR  = 9'b010000000,
        S_EMW  = 9'b100000000
    } state_t;

    state_t      state_reg, state_next;
    logic [6:0]  ld_reg, ld_next;
    logic [3:0]  p_reg, p_next;
    logic [2:0]  q_reg, q_next;
    logic [1:0]  h_reg, h_next;
    logic [1:0]  w_reg, w_next;
    logic [5:0]  k_reg, k_next;
    logic [63:0] a_reg, a_next, b_reg, b_next, c_reg, c_next, d_reg, d_next;
    logic [63:0] m_reg;
    logic        ov_reg, ov_next;
    logic [63:0] lo_reg, hi_reg;
    logic        lp_reg;

    logic [63:0] work_mem [0:BLOCK_WORDS-1];
    logic [63:0] xor_mem  [0:BLOCK_WORDS-1];
    logic [63:0] wr0_reg, wr1_reg, xr0_reg, xr1_reg;
    logic [6:0]  ra0, ra1, wa;
    logic [63:0] wd;
    logic        rd_en, wk_we, ld_we, out_load;
    logic [31:0] mx, my;
    logic [63:0] sum;

    assign empty     = !ov_reg;
    assign low_word  = lo_reg;
    assign high_word = hi_reg;
    assign last_pair = lp_reg;
    assign ld_we     = (state_reg == S_LOAD) && q_valid;
    assign q_pop     = ld_we;
    assign out_load  = (state_reg == S_EMW) && (!ov_reg || pop);

    always_comb
    begin
        ra0   = word_addr(p_reg, QUAD_IDX[q_reg][0]);
        ra1   = word_addr(p_reg, QUAD_IDX[q_reg][1]);
        rd_en = 1'b0;
        case (state_reg)
            S_RDA:
            begin
                rd_en = 1'b1;
            end
            S_RDB:
            begin
                ra0   = word_addr(p_reg, QUAD_IDX[q_reg][2]);
                ra1   = word_addr(p_reg, QUAD_IDX[q_reg][3]);
                rd_en = 1'b1;
            end
            S_EMR:
            begin
                ra0   = {k_reg, 1'b0};
                ra1   = {k_reg, 1'b1};
                rd_en = 1'b1;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        wk_we = ld_we || (state_reg == S_WR);
        wa    = ld_we ? ld_reg : word_addr(p_reg, QUAD_IDX[q_reg][w_reg]);
        case (w_reg)
            2'd0:    wd = a_reg;
            2'd1:    wd = b_reg;
            2'd2:    wd = c_reg;
            default: wd = d_reg;
        endcase
        if (ld_we)
        begin
            wd = q_data.word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wk_we)
        begin
            work_mem[wa] <= wd;
        end
        if (ld_we)
        begin
            xor_mem[ld_reg] <= q_data.word;
        end
        if (rd_en)
        begin
            wr0_reg <= work_mem[ra0];
            wr1_reg <= work_mem[ra1];
            xr0_reg <= xor_mem[ra0];
            xr1_reg <= xor_mem[ra1];
        end
    end

    assign mx = h_reg[0] ? c_reg[31:0] : a_reg[31:0];
    assign my = h_reg[0] ? d_reg[31:0] : b_reg[31:0];

    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL)
        begin
            m_reg <= 64'(mx) * 64'(my);
        end
    end

    assign sum = h_reg[0] ? (c_reg + d_reg + {m_reg[62:0], 1'b0})
                          : (a_reg + b_reg + {m_reg[62:0], 1'b0});

    always_comb
    begin
        state_next = state_reg;
        ld_next    = ld_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        h_next     = h_reg;
        w_next     = w_reg;
        k_next     = k_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        ov_next    = ov_reg;
        if (pop && ov_reg)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            S_LOAD:
            begin
                if (q_valid)
                begin
                    ld_next = ld_reg + 7'd1;
                    if (q_data.last)
                    begin
                        ld_next    = '0;
                        p_next     = '0;
                        q_next     = '0;
                        state_next = S_RDA;
                    end
                end
            end
            S_RDA:
            begin
                state_next = S_RDB;
            end
            S_RDB:
            begin
                a_next     = wr0_reg;
                b_next     = wr1_reg;
                state_next = S_RDC;
            end
            S_RDC:
            begin
                c_next     = wr0_reg;
                d_next     = wr1_reg;
                h_next     = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                case (h_reg)
                    2'd0:
                    begin
                        a_next = sum;
                        d_next = rotr(d_reg ^ sum, 32);
                    end
                    2'd1:
                    begin
                        c_next = sum;
                        b_next = rotr(b_reg ^ sum, 24);
                    end
                    2'd2:
                    begin
                        a_next = sum;
                        d_next = rotr(d_reg ^ sum, 16);
                    end
                    default:
                    begin
                        c_next = sum;
                        b_next = rotr(b_reg ^ sum, 63);
                    end
                endcase
                h_next = h_reg + 2'd1;
                if (h_reg == 2'd3)
                begin
                    w_next     = '0;
                    state_next = S_WR;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_WR:
            begin
                w_next = w_reg + 2'd1;
                if (w_reg == 2'd3)
                begin
                    q_next     = q_reg + 3'd1;
                    state_next = S_RDA;
                    if (q_reg == 3'd7)
                    begin
                        p_next = p_reg + 4'd1;
                        if (p_reg == 4'd15)
                        begin
                            k_next     = '0;
                            state_next = S_EMR;
                        end
                    end
                end
            end
            S_EMR:
            begin
                state_next = S_EMW;
            end
            S_EMW:
            begin
                if (out_load)
                begin
                    ov_next    = 1'b1;
                    k_next     = k_reg + 6'd1;
                    state_next = (k_reg == 6'(BLOCK_WORDS / 2 - 1)) ? S_LOAD : S_EMR;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        if (out_load)
        begin
            lo_reg <= xr0_reg ^ wr0_reg;
            hi_reg <= xr1_reg ^ wr1_reg;
            lp_reg <= k_reg == 6'(BLOCK_WORDS / 2 - 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            ld_reg    <= '0;
            p_reg     <= '0;
            q_reg     <= '0;
            h_reg     <= '0;
            w_reg     <= '0;
            k_reg     <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ld_reg    <= ld_next;
            p_reg     <= p_next;
            q_reg     <= q_next;
            h_reg     <= h_next;
            w_reg     <= w_next;
            k_reg     <= k_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

@@ sv/argon2_block_compress_unit.sv @@
`timescale 1ns / 1ps
// channel   dir  handshake           fields
// input     in   push / full         x_word, y_word
// result    out  empty / pop         low_word, high_word, last_pair
//
// the back end loads words from the queue only in its load state; each of the 128
// quarter-rounds takes two memory reads, four multiply-add steps and four writes,
// then 64 result pairs are emitted, each held until it is popped
// the four-deep input queue takes up to four words while the back end computes
// reset clears queue pointers, counters and state; block stores are not cleared
module argon2_block_compress_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [63:0] x_word,
    input  logic [63:0] y_word,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] low_word,
    output logic [63:0] high_word,
    output logic        last_pair
);
    import a2bc_pkg::*;

    logic    q_valid, q_pop;
    q_word_t q_data;

    a2bc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .x_word  (x_word),
        .y_word  (y_word),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop)
    );

    a2bc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .low_word  (low_word),
        .high_word (high_word),
        .last_pair (last_pair)
    );

endmodule

@@ sv/a2bc_checker.sv @@
`timescale 1ns / 1ps
module a2bc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [63:0] low_word,
    input logic [63:0] high_word,
    input logic        last_pair
);
    logic [5:0] pops_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pops_reg <= '0;
        end
        else if (pop && !empty)
        begin
            pops_reg <= pops_reg + 6'd1;
        end
    end

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result queue not empty in reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(low_word) && $stable(high_word)))
        else $error("waiting result word changed");

    a_last_set: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pops_reg == 6'd63) |-> last_pair)
        else $error("last_pair missing on final pair");

    a_last_clr: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pops_reg != 6'd63) |-> !last_pair)
        else $error("last_pair set early");

endmodule

bind argon2_block_compress_unit a2bc_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .low_word  (low_word),
    .high_word (high_word),
    .last_pair (last_pair)
);
